/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the channel state cache.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* hdl/mcsc_pkg.sv */
// ----------------------------------------------------------------------------
// mcsc_pkg
// Types and constants shared by the channel state cache modules.
// ----------------------------------------------------------------------------
package mcsc_pkg;

  localparam int STATUS_W   = 8;
  localparam int DATA_W     = 7;
  localparam int CHAN_W     = 4;
  localparam int FIFO_DEPTH = 2;

  // Action codes of an input beat.
  typedef enum logic [1:0] {
    ACT_SAVE   = 2'd0,
    ACT_REPLAY = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  // Status high nibbles that take part in matching.
  localparam logic [3:0] KIND_AFTERTOUCH = 4'hA;
  localparam logic [3:0] KIND_CTRL_CHG   = 4'hB;
  localparam logic [3:0] KIND_PROG_CHG   = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
  localparam logic [3:0] KIND_PITCH_BEND = 4'hE;

  // Classified operation handed from the front end to the engine.
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_MATCH_FIRST,
    OP_MATCH_STATUS,
    OP_REPLAY,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [CHAN_W-1:0]   ch;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   first;
    logic [DATA_W-1:0]   second;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   first;
    logic [DATA_W-1:0]   second;
  } entry_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_APPEND,
    ENG_RP_RD,
    ENG_RP_OUT
  } eng_state_e;

endpackage

/* hdl/mcsc_front.sv */
// ----------------------------------------------------------------------------
// mcsc_front
// Accepts input beats, classifies them into engine commands and drops the
// ones that have no effect.
// ----------------------------------------------------------------------------
module mcsc_front #(
  parameter int CHANNELS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [mcsc_pkg::STATUS_W-1:0]   status_byte_i,
  input  logic [mcsc_pkg::DATA_W-1:0]     data_first_i,
  input  logic [mcsc_pkg::DATA_W-1:0]     data_second_i,
  input  logic [mcsc_pkg::CHAN_W-1:0]     replay_channel_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output mcsc_pkg::cmd_t                  cmd_o
);

  logic           vld_q, vld_d;
  mcsc_pkg::cmd_t cmd_q, cmd_d;
  mcsc_pkg::cmd_t cls;
  logic           keep;
  logic [3:0]     kind;
  logic           accept;

  assign kind       = status_byte_i[7:4];
  assign in_ready_o = !vld_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classification. Saves to a channel beyond the configured count, replays
  // of such a channel and the unused action code are dropped here.
  always_comb begin
    cls        = '0;
    cls.op     = mcsc_pkg::OP_APPEND;
    cls.status = status_byte_i;
    cls.first  = data_first_i;
    cls.second = data_second_i;
    cls.ch     = status_byte_i[3:0];
    keep       = 1'b0;
    case (mcsc_pkg::action_e'(action_i))
      mcsc_pkg::ACT_SAVE: begin
        keep = ({1'b0, status_byte_i[3:0]} < 5'(CHANNELS));
        if (kind inside {mcsc_pkg::KIND_AFTERTOUCH, mcsc_pkg::KIND_CTRL_CHG}) begin
          cls.op = mcsc_pkg::OP_MATCH_FIRST;
        end else if (kind inside {mcsc_pkg::KIND_PROG_CHG, mcsc_pkg::KIND_CHAN_PRESS,
                                  mcsc_pkg::KIND_PITCH_BEND}) begin
          cls.op = mcsc_pkg::OP_MATCH_STATUS;
        end else begin
          cls.op = mcsc_pkg::OP_APPEND;
        end
      end
      mcsc_pkg::ACT_REPLAY: begin
        cls.op = mcsc_pkg::OP_REPLAY;
        cls.ch = replay_channel_i;
        keep   = ({1'b0, replay_channel_i} < 5'(CHANNELS));
      end
      mcsc_pkg::ACT_CLEAR: begin
        cls.op = mcsc_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (vld_q && cmd_ready_i) begin
      vld_d = 1'b0;
    end
    if (accept && keep) begin
      vld_d = 1'b1;
      cmd_d = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

/* hdl/mcsc_fifo.sv */
// ----------------------------------------------------------------------------
// mcsc_fifo
// Short command queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcsc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mcsc_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mcsc_pkg::cmd_t pop_data_o
);

  localparam int PTR_W = $clog2(mcsc_pkg::FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  mcsc_pkg::cmd_t   slot_q [mcsc_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(mcsc_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_CLK(a_fifo_cnt_max, clk_i, rst_ni, cnt_q <= CNT_W'(mcsc_pkg::FIFO_DEPTH), "fifo overfilled")
  `ASSERT_CLK(a_fifo_cnt_track, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "fifo count lost a push")

endmodule

/* hdl/mcsc_engine.sv */
// ----------------------------------------------------------------------------
// mcsc_engine
// Carries out commands on the entry table: match scan, update or append,
// replay in insertion order and clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcsc_engine #(
  parameter int CHANNELS            = 16,
  parameter int ENTRIES_PER_CHANNEL = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  mcsc_pkg::cmd_t                cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcsc_pkg::STATUS_W-1:0] out_status_o,
  output logic [mcsc_pkg::DATA_W-1:0]   out_first_o,
  output logic [mcsc_pkg::DATA_W-1:0]   out_second_o,
  output logic                          last_entry_o
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W  = (ENTRIES_PER_CHANNEL > 1) ? $clog2(ENTRIES_PER_CHANNEL) : 1;
  localparam int CNT_W  = $clog2(ENTRIES_PER_CHANNEL + 1);
  localparam int ADDR_W = CH_W + IDX_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  mcsc_pkg::eng_state_e state_q, state_d;
  mcsc_pkg::cmd_t       cmd_q, cmd_d;
  logic [CNT_W-1:0]     cnt_q [CHANNELS];
  logic [CNT_W-1:0]     cnt_d [CHANNELS];
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 chk_v_q, chk_v_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;

  mcsc_pkg::entry_t     mem_q [DEPTH];
  mcsc_pkg::entry_t     rdata_q;
  mcsc_pkg::entry_t     wr_data;
  logic                 rd_en, wr_en;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;

  logic                 out_valid_q, out_valid_d;
  mcsc_pkg::entry_t     out_q, out_d;
  logic                 out_last_q, out_last_d;

  logic [CH_W-1:0]      ch;
  logic [CNT_W-1:0]     cur_cnt;
  logic                 pop, issue, hit, room, scan_done, out_free, is_last;

  assign ch        = cmd_q.ch[CH_W-1:0];
  assign cur_cnt   = cnt_q[ch];
  assign pop       = (state_q == mcsc_pkg::ENG_IDLE) && cmd_valid_i;
  assign issue     = (rd_idx_q < cur_cnt);
  assign hit       = chk_v_q && (rdata_q.status == cmd_q.status) &&
                     ((cmd_q.op != mcsc_pkg::OP_MATCH_FIRST) || (rdata_q.first == cmd_q.first));
  assign scan_done = !issue && !chk_v_q;
  assign room      = (cur_cnt < CNT_W'(ENTRIES_PER_CHANNEL));
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_last   = (({1'b0, rd_idx_q} + (CNT_W + 1)'(1)) == {1'b0, cur_cnt});
  assign cmd_ready_o = (state_q == mcsc_pkg::ENG_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcsc_pkg::ENG_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            mcsc_pkg::OP_MATCH_FIRST,
            mcsc_pkg::OP_MATCH_STATUS: state_d = mcsc_pkg::ENG_SCAN;
            mcsc_pkg::OP_APPEND:       state_d = mcsc_pkg::ENG_APPEND;
            mcsc_pkg::OP_REPLAY:       state_d = mcsc_pkg::ENG_RP_RD;
            default:                   state_d = mcsc_pkg::ENG_IDLE;
          endcase
        end
      end
      mcsc_pkg::ENG_SCAN: begin
        if (hit || scan_done) begin
          state_d = mcsc_pkg::ENG_IDLE;
        end
      end
      mcsc_pkg::ENG_APPEND: begin
        state_d = mcsc_pkg::ENG_IDLE;
      end
      mcsc_pkg::ENG_RP_RD: begin
        state_d = issue ? mcsc_pkg::ENG_RP_OUT : mcsc_pkg::ENG_IDLE;
      end
      mcsc_pkg::ENG_RP_OUT: begin
        if (out_free) begin
          state_d = mcsc_pkg::ENG_RP_RD;
        end
      end
      default: begin
        state_d = mcsc_pkg::ENG_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = {ch, rd_idx_q[IDX_W-1:0]};
    wr_addr     = {ch, cur_cnt[IDX_W-1:0]};
    wr_data     = '{status: cmd_q.status, first: cmd_q.first, second: cmd_q.second};
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    out_last_d  = out_last_q;
    case (state_q)
      mcsc_pkg::ENG_IDLE: begin
        if (pop) begin
          cmd_d    = cmd_i;
          rd_idx_d = '0;
          if (cmd_i.op == mcsc_pkg::OP_CLEAR) begin
            for (int c = 0; c < CHANNELS; c++) begin
              cnt_d[c] = '0;
            end
          end
        end
      end
      mcsc_pkg::ENG_SCAN: begin
        // One read per cycle; the compare sees the entry read in the cycle before.
        // A matching entry is overwritten whole: status, and for aftertouch
        // and control change also the first byte, are equal already.
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = {ch, chk_idx_q};
        end else begin
          if (issue) begin
            rd_en     = 1'b1;
            chk_v_d   = 1'b1;
            chk_idx_d = rd_idx_q[IDX_W-1:0];
            rd_idx_d  = rd_idx_q + CNT_W'(1);
          end
          if (scan_done && room) begin
            wr_en     = 1'b1;
            cnt_d[ch] = cur_cnt + CNT_W'(1);
          end
        end
      end
      mcsc_pkg::ENG_APPEND: begin
        if (room) begin
          wr_en     = 1'b1;
          cnt_d[ch] = cur_cnt + CNT_W'(1);
        end
      end
      mcsc_pkg::ENG_RP_RD: begin
        rd_en = issue;
      end
      mcsc_pkg::ENG_RP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = rdata_q;
          out_last_d  = is_last;
          rd_idx_d    = rd_idx_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcsc_pkg::ENG_IDLE;
      cmd_q       <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // Entry table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_q.status;
  assign out_first_o  = out_q.first;
  assign out_second_o = out_q.second;
  assign last_entry_o = out_last_q;

  `ASSERT_NEVER(a_rw_excl, clk_i, rst_ni, wr_en && rd_en, "table read and write in one cycle")
  `ASSERT_CLK(a_cnt_max, clk_i, rst_ni, cur_cnt <= CNT_W'(ENTRIES_PER_CHANNEL), "channel count overflow")
  `ASSERT_CLK(a_scan_op, clk_i, rst_ni, (state_q == mcsc_pkg::ENG_SCAN) |-> ((cmd_q.op == mcsc_pkg::OP_MATCH_FIRST) || (cmd_q.op == mcsc_pkg::OP_MATCH_STATUS)), "scan without a match command")
  `ASSERT_CLK(a_rp_idx, clk_i, rst_ni, (state_q == mcsc_pkg::ENG_RP_OUT) |-> (rd_idx_q < cur_cnt), "replay beyond channel count")

endmodule

/* hdl/midi_channel_state_cache_unit.sv */
// ----------------------------------------------------------------------------
// midi_channel_state_cache_unit
// Per-channel cache of the latest MIDI controller and voice state, with
// in-place update, insertion-ordered replay and clear.
// ----------------------------------------------------------------------------
// The input channel takes one command per beat: save an event, replay one
// channel, or clear all channels. The output channel returns one beat per
// stored entry of a replayed channel, with last_entry_o set on the final one.
// Save and clear produce no output beats; neither does a replay of an empty
// channel or of a channel beyond CHANNELS.
// A front stage classifies each beat and a two-entry command queue lets it
// keep accepting while the engine works. A save of a matching kind scans its
// channel at one table read per cycle; other statuses append directly, and a
// clear resets every channel count. A replay alternates between reading an
// entry through the single read port of the entry table and loading it into
// the output register.
// Reset empties all channels and the queue at once; no clearing pass is
// needed because only entries below a channel's count are ever read.
// When the receiver stalls, the output register holds its beat, the engine
// waits, and the queue then the front stage fill before in_ready_o drops.
// ----------------------------------------------------------------------------
module midi_channel_state_cache_unit #(
  parameter int CHANNELS            = 16,
  parameter int ENTRIES_PER_CHANNEL = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [mcsc_pkg::STATUS_W-1:0] status_byte_i,
  input  logic [mcsc_pkg::DATA_W-1:0]   data_first_i,
  input  logic [mcsc_pkg::DATA_W-1:0]   data_second_i,
  input  logic [mcsc_pkg::CHAN_W-1:0]   replay_channel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcsc_pkg::STATUS_W-1:0] out_status_o,
  output logic [mcsc_pkg::DATA_W-1:0]   out_first_o,
  output logic [mcsc_pkg::DATA_W-1:0]   out_second_o,
  output logic                          last_entry_o
);

  // Front stage to queue.
  logic           fq_valid, fq_ready;
  mcsc_pkg::cmd_t fq_cmd;

  // Queue to engine.
  logic           qe_valid, qe_ready;
  mcsc_pkg::cmd_t qe_cmd;

  // The front stage drops commands with no effect, so the engine only sees
  // work that touches the table or the output.
  mcsc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .status_byte_i    (status_byte_i),
    .data_first_i     (data_first_i),
    .data_second_i    (data_second_i),
    .replay_channel_i (replay_channel_i),
    .cmd_valid_o      (fq_valid),
    .cmd_ready_i      (fq_ready),
    .cmd_o            (fq_cmd)
  );

  // Commands keep their order through the queue, so a clear never overtakes
  // an earlier save or replay.
  mcsc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_data_o   (qe_cmd)
  );

  // The engine owns the entry table, the per-channel counts and the output
  // register.
  mcsc_engine #(
    .CHANNELS            (CHANNELS),
    .ENTRIES_PER_CHANNEL (ENTRIES_PER_CHANNEL)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (qe_valid),
    .cmd_ready_o  (qe_ready),
    .cmd_i        (qe_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_status_o (out_status_o),
    .out_first_o  (out_first_o),
    .out_second_o (out_second_o),
    .last_entry_o (last_entry_o)
  );

endmodule

/* sim/midi_channel_state_cache_unit_test.sv */
// ----------------------------------------------------------------------------
// midi_channel_state_cache_unit_test
// Self-checking bench for the MIDI channel state cache. A clocked driver
// sends command beats from a pending queue and updates a shadow cache when
// each beat is accepted. The shadow cache predicts every replay beat. A
// clocked monitor stalls at random and compares each output beat with the
// oldest predicted beat.
// ----------------------------------------------------------------------------
module midi_channel_state_cache_unit_test;

  localparam int NUM_CH    = 16;
  localparam int SLOTS     = 16;
  localparam int RAND_CMDS = 187;
  localparam int IDLE_PCT  = 26;
  localparam int HOLD_LEN  = 400;
  localparam int MAX_PRINT = 40;

  // One command beat as presented on the input channel.
  typedef struct {
    logic [1:0]                    action;
    logic [mcsc_pkg::STATUS_W-1:0] status;
    logic [mcsc_pkg::DATA_W-1:0]   first;
    logic [mcsc_pkg::DATA_W-1:0]   second;
    logic [mcsc_pkg::CHAN_W-1:0]   chan;
  } cache_cmd_t;

  // One predicted replay beat.
  typedef struct {
    mcsc_pkg::entry_t ent;
    logic             is_last;
  } replay_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    action = '0;
  logic [mcsc_pkg::STATUS_W-1:0] status_byte = '0;
  logic [mcsc_pkg::DATA_W-1:0]   data_first = '0;
  logic [mcsc_pkg::DATA_W-1:0]   data_second = '0;
  logic [mcsc_pkg::CHAN_W-1:0]   replay_chan = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mcsc_pkg::STATUS_W-1:0] out_status;
  logic [mcsc_pkg::DATA_W-1:0]   out_first;
  logic [mcsc_pkg::DATA_W-1:0]   out_second;
  logic                          last_entry;

  cache_cmd_t   pending_cmds[$];
  replay_beat_t replay_expect[$];

  // Shadow copy of the cache contents.
  mcsc_pkg::entry_t cache_mem [NUM_CH][SLOTS];
  int               fill_level [NUM_CH] = '{default: 0};

  int          err_count = 0;
  int unsigned cycle_no = 0;
  logic        calm;

  midi_channel_state_cache_unit #(
    .CHANNELS           (NUM_CH),
    .ENTRIES_PER_CHANNEL(SLOTS)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .status_byte_i   (status_byte),
    .data_first_i    (data_first),
    .data_second_i   (data_second),
    .replay_channel_i(replay_chan),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_status_o    (out_status),
    .out_first_o     (out_first),
    .out_second_o    (out_second),
    .last_entry_o    (last_entry)
  );

  always #1 clk = ~clk;

  // Free-running cycle count; updated nonblocking so every process sees the
  // same value at an edge.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Neither side idles inside this window.
  assign calm = (cycle_no >= 1000) && (cycle_no < 1800);

  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINT) begin
      $display("ERROR @%0d: %s", cycle_no, msg);
    end
    err_count++;
  endtask

  // Applies one accepted command to the shadow cache and queues the replay
  // beats that it produces.
  task automatic update_cache_model(input cache_cmd_t cmd);
    logic [mcsc_pkg::CHAN_W-1:0] ch;
    logic [3:0]                  kind;
    int                          hit;
    int                          n;
    replay_beat_t                beat;
    hit = -1;
    case (cmd.action)
      mcsc_pkg::ACT_SAVE: begin
        ch   = cmd.status[mcsc_pkg::CHAN_W-1:0];
        kind = cmd.status[7:4];
        if (ch < NUM_CH) begin
          n = fill_level[ch];
          if (kind == mcsc_pkg::KIND_AFTERTOUCH || kind == mcsc_pkg::KIND_CTRL_CHG) begin
            // Same status and same controller: only the value moves.
            for (int i = 0; i < n; i++) begin
              if (hit < 0 && cache_mem[ch][i].status == cmd.status &&
                  cache_mem[ch][i].first == cmd.first) begin
                hit = i;
              end
            end
            if (hit >= 0) cache_mem[ch][hit].second = cmd.second;
          end else if (kind == mcsc_pkg::KIND_PROG_CHG || kind == mcsc_pkg::KIND_CHAN_PRESS ||
                       kind == mcsc_pkg::KIND_PITCH_BEND) begin
            // Same status alone: both data bytes move.
            for (int i = 0; i < n; i++) begin
              if (hit < 0 && cache_mem[ch][i].status == cmd.status) hit = i;
            end
            if (hit >= 0) begin
              cache_mem[ch][hit].first  = cmd.first;
              cache_mem[ch][hit].second = cmd.second;
            end
          end
          // A full channel drops the event without a trace.
          if (hit < 0 && n < SLOTS) begin
            cache_mem[ch][n] = '{status: cmd.status, first: cmd.first,
                                 second: cmd.second};
            fill_level[ch] = n + 1;
          end
        end
      end
      mcsc_pkg::ACT_REPLAY: begin
        if (cmd.chan < NUM_CH) begin
          n = fill_level[cmd.chan];
          for (int i = 0; i < n; i++) begin
            beat.ent     = cache_mem[cmd.chan][i];
            beat.is_last = (i == n - 1);
            replay_expect.push_back(beat);
          end
        end
      end
      mcsc_pkg::ACT_CLEAR: begin
        for (int c = 0; c < NUM_CH; c++) fill_level[c] = 0;
      end
      default: begin
        // The spare action code leaves everything untouched.
      end
    endcase
  endtask

  // Fields that a command does not use get random values so that every
  // input bit toggles.
  task automatic queue_save(input logic [7:0] st, input int fb, input int sb);
    cache_cmd_t cmd;
    cmd.action = mcsc_pkg::ACT_SAVE;
    cmd.status = st;
    cmd.first  = mcsc_pkg::DATA_W'(fb);
    cmd.second = mcsc_pkg::DATA_W'(sb);
    cmd.chan   = mcsc_pkg::CHAN_W'($urandom_range(15));
    pending_cmds.push_back(cmd);
  endtask

  task automatic queue_replay(input int ch);
    cache_cmd_t cmd;
    cmd.action = mcsc_pkg::ACT_REPLAY;
    cmd.status = mcsc_pkg::STATUS_W'($urandom_range(255));
    cmd.first  = mcsc_pkg::DATA_W'($urandom_range(127));
    cmd.second = mcsc_pkg::DATA_W'($urandom_range(127));
    cmd.chan   = mcsc_pkg::CHAN_W'(ch);
    pending_cmds.push_back(cmd);
  endtask

  task automatic queue_raw(input int act);
    cache_cmd_t cmd;
    cmd.action = 2'(act);
    cmd.status = mcsc_pkg::STATUS_W'($urandom_range(255));
    cmd.first  = mcsc_pkg::DATA_W'($urandom_range(127));
    cmd.second = mcsc_pkg::DATA_W'($urandom_range(127));
    cmd.chan   = mcsc_pkg::CHAN_W'($urandom_range(15));
    pending_cmds.push_back(cmd);
  endtask

  // Driver: a new beat is offered only when the last one has gone, so valid
  // and payload hold steady until accepted.
  always @(posedge clk) begin
    cache_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cmd.action = action;
        cmd.status = status_byte;
        cmd.first  = data_first;
        cmd.second = data_second;
        cmd.chan   = replay_chan;
        update_cache_model(cmd);
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cmd = pending_cmds.pop_front();
          action      <= cmd.action;
          status_byte <= cmd.status;
          data_first  <= cmd.first;
          data_second <= cmd.second;
          replay_chan <= cmd.chan;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold: once, early in the run, ready stays low for a long
  // stretch so that the output register, the command queue and the front
  // stage all fill and the input side stalls.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n && !hold_done && cycle_no >= 300 && out_valid) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end
  end

  // Monitor: checks each output beat and drives ready.
  always @(posedge clk) begin
    replay_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replay_expect.size() == 0) begin
          flag_error($sformatf("unexpected beat status %02h", out_status));
        end else begin
          want = replay_expect.pop_front();
          if (out_status !== want.ent.status)
            flag_error($sformatf("status got %02h want %02h", out_status, want.ent.status));
          if (out_first !== want.ent.first)
            flag_error($sformatf("first got %02h want %02h", out_first, want.ent.first));
          if (out_second !== want.ent.second)
            flag_error($sformatf("second got %02h want %02h", out_second, want.ent.second));
          if (last_entry !== want.is_last)
            flag_error($sformatf("last got %0b want %0b", last_entry, want.is_last));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int ch;
    int n;
    int pick;
    logic [3:0] kind;

    // Directed part: every action, every matching kind, update and append
    // paths, the byte extremes, an empty replay and the spare action code.
    queue_raw(mcsc_pkg::ACT_CLEAR);
    queue_replay(0);
    queue_save(8'hA0, 5, 10);
    queue_save(8'hA0, 5, 20);
    queue_save(8'hA0, 6, 30);
    queue_save(8'hB0, 127, 127);
    queue_save(8'hB0, 127, 0);
    queue_save(8'hC0, 1, 2);
    queue_save(8'hC0, 100, 101);
    queue_save(8'hD0, 0, 0);
    queue_save(8'hD0, 127, 127);
    queue_save(8'hE0, 0, 127);
    queue_save(8'hE0, 127, 0);
    queue_save(8'h00, 0, 0);
    queue_save(8'h90, 64, 100);
    queue_save(8'h90, 64, 100);
    queue_save(8'hF0, 127, 127);
    queue_replay(0);
    queue_save(8'hFF, 127, 127);
    queue_save(8'h9F, 1, 1);
    queue_raw(3);
    queue_replay(15);
    queue_raw(mcsc_pkg::ACT_CLEAR);
    queue_replay(0);

    // Random part: mostly short sessions on one channel with few distinct
    // controllers so that updates hit, then a replay of that channel. Floods
    // push channels into the full state. Clears are rare so that channels
    // accumulate.
    n = pending_cmds.size();
    while (pending_cmds.size() < n + RAND_CMDS) begin
      pick = $urandom_range(99);
      ch   = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(15);
      if (pick < 55) begin
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(9) < 8) kind = 4'(mcsc_pkg::KIND_AFTERTOUCH + $urandom_range(4));
          else kind = 4'($urandom_range(15));
          queue_save({kind, 4'(ch)},
                     ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(3),
                     $urandom_range(127));
        end
        if ($urandom_range(3) != 0) queue_replay(ch);
      end else if (pick < 65) begin
        repeat ($urandom_range(4, 18)) begin
          queue_save({4'h9, 4'(ch)}, $urandom_range(127), $urandom_range(127));
        end
        queue_replay(ch);
      end else if (pick < 69) begin
        queue_raw(mcsc_pkg::ACT_CLEAR);
      end else if (pick < 80) begin
        queue_replay($urandom_range(15));
      end else begin
        queue_raw($urandom_range(3));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Every command must be accepted, then every predicted beat seen.
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (replay_expect.size() != 0) @(posedge clk);
    // Saves may still be scanning; give them time to show any stray beat.
    repeat (200) @(posedge clk);

    if (err_count == 0 && replay_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/mcsc_pkg.sv
hdl/mcsc_front.sv
hdl/mcsc_fifo.sv
hdl/mcsc_engine.sv
hdl/midi_channel_state_cache_unit.sv
sim/midi_channel_state_cache_unit_test.sv
